// ===== src/rfsw_pkg.sv =====
// Shared types, constants and word-building functions for the RF switch/attenuator controller.
`timescale 1ns / 1ps
`default_nettype none

package rfsw_pkg;

	localparam int WORD_W  = 16;
	localparam int CHAN_W  = 3;
	localparam int ATTEN_W = 6;
	localparam int ATIN_W  = 8;
	localparam int WB_W    = 2;
	localparam int BIT_CNT_W = 4;

	localparam logic [WORD_W-1:0]  WORD_RESET  = 16'h0130;
	localparam logic [ATTEN_W-1:0] ATTEN_RESET = 6'd40;
	localparam logic [ATTEN_W-1:0] ATTEN_MAX   = 6'd63;
	localparam logic [WORD_W-1:0]  ATTEN_MASK  = 16'hF003;
	localparam logic [CHAN_W-1:0]  CHAN_ATTEN  = 3'd1;
	localparam logic [BIT_CNT_W-1:0] BIT_LAST  = 4'd15;

	// Channel words
	localparam logic [WORD_W-1:0] CHAN0_WORD = 16'h0130;
	localparam logic [WORD_W-1:0] CHAN1_WORD = 16'h1824;
	localparam logic [WORD_W-1:0] CHAN2_WORD = 16'h0418;
	localparam logic [WORD_W-1:0] CHAN3_WORD = 16'h020C;

	typedef enum logic [1:0] {
		CMD_SET_CHAN  = 2'd0,
		CMD_SET_ATTEN = 2'd1,
		CMD_SET_W     = 2'd2,
		CMD_RAW       = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LOAD,
		ST_WAIT,
		ST_SEND,
		ST_ATTEN
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LATCH,
		OP_APPLY_CMD,
		OP_APPLY_ATTEN,
		OP_LOAD_FRAME,
		OP_NEXT_BIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   tmr_start;
	} dp_cmd_t;

	typedef struct packed {
		logic has_frame;
		logic two_frames;
		logic bit_last;
		logic tmr_done;
	} dp_sts_t;

	function automatic logic [WORD_W-1:0] chan_word(input logic [CHAN_W-1:0] ch);
		logic [WORD_W-1:0] w;
		case (ch)
			3'd0:    w = CHAN0_WORD;
			3'd1:    w = CHAN1_WORD;
			3'd2:    w = CHAN2_WORD;
			default: w = CHAN3_WORD;
		endcase
		return w;
	endfunction

	// Inverted attenuation goes to bits 15:12 (low nibble) and 1:0 (top two bits)
	function automatic logic [WORD_W-1:0] apply_atten(input logic [WORD_W-1:0] word,
			input logic [ATTEN_W-1:0] att);
		logic [ATTEN_W-1:0] t;
		logic [WORD_W-1:0]  w;
		t = ~att;
		w = word & ~ATTEN_MASK;
		w[15:12] = t[3:0];
		w[1:0]   = t[5:4];
		return w;
	endfunction

	// Saturate signed half-dB value into 0..63
	function automatic logic [ATTEN_W-1:0] sat_atten(input logic [ATIN_W-1:0] a);
		logic [ATTEN_W-1:0] r;
		if (a[ATIN_W-1])
			r = '0;
		else if (a[ATIN_W-2:ATTEN_W] != '0)
			r = ATTEN_MAX;
		else
			r = a[ATTEN_W-1:0];
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/rfsw_ctrl.sv =====
// Sequencing state machine: command execution, per-bit timing and beat handshakes.
`timescale 1ns / 1ps
`default_nettype none

module rfsw_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic                 m_tlast,
	output rfsw_pkg::dp_cmd_t    dp_cmd,
	input  wire rfsw_pkg::dp_sts_t dp_sts
);
	import rfsw_pkg::*;

	state_t state_q, state_nxt;
	logic   second_q;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:  if (s_tvalid) state_nxt = ST_EXEC;
			ST_EXEC:  state_nxt = dp_sts.has_frame ? ST_LOAD : ST_IDLE;
			ST_LOAD:  state_nxt = ST_WAIT;
			ST_WAIT:  if (dp_sts.tmr_done) state_nxt = ST_SEND;
			ST_SEND: begin
				if (m_tready) begin
					if (!dp_sts.bit_last)
						state_nxt = ST_WAIT;
					else if (second_q)
						state_nxt = ST_ATTEN;
					else
						state_nxt = ST_IDLE;
				end
			end
			ST_ATTEN: state_nxt = ST_LOAD;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// Outputs and datapath commands
	always_comb begin
		s_tready         = 1'b0;
		m_tvalid         = 1'b0;
		m_tlast          = 1'b0;
		dp_cmd.op        = OP_NONE;
		dp_cmd.tmr_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) dp_cmd.op = OP_LATCH;
			end
			ST_EXEC:  dp_cmd.op = OP_APPLY_CMD;
			ST_LOAD: begin
				dp_cmd.op        = OP_LOAD_FRAME;
				dp_cmd.tmr_start = 1'b1;
			end
			ST_WAIT:  ;
			ST_SEND: begin
				m_tvalid = 1'b1;
				m_tlast  = dp_sts.bit_last & ~second_q;
				if (m_tready && !dp_sts.bit_last) begin
					dp_cmd.op        = OP_NEXT_BIT;
					dp_cmd.tmr_start = 1'b1;
				end
			end
			ST_ATTEN: dp_cmd.op = OP_APPLY_ATTEN;
			default:  ;
		endcase
	end

	// State and second-frame flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			second_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_EXEC)
				second_q <= dp_sts.two_frames;
			else if (state_q == ST_ATTEN)
				second_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ===== src/rfsw_dp.sv =====
// Datapath: control word state, frame shifter and bit timer.
`timescale 1ns / 1ps
`default_nettype none

module rfsw_dp #(
	parameter int NUM_DEVICES      = 2,
	parameter int BIT_DELAY_CYCLES = 100
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [1:0]                     in_cmd,
	input  wire logic [rfsw_pkg::CHAN_W-1:0]    in_channel,
	input  wire logic [rfsw_pkg::ATIN_W-1:0]    in_atten,
	input  wire logic [rfsw_pkg::WB_W-1:0]      in_w,
	input  wire logic [rfsw_pkg::WORD_W-1:0]    in_raw,
	input  wire logic                           cfg_we,
	input  wire logic                           cfg_wdata,
	input  wire rfsw_pkg::dp_cmd_t              dp_cmd,
	output rfsw_pkg::dp_sts_t                   dp_sts,
	output logic                                chip_select,
	output logic                                data_bit,
	output logic [rfsw_pkg::WORD_W-1:0]         frame_word
);
	import rfsw_pkg::*;

	// Each bit spans three delay phases
	localparam int BIT_CYCLES = 3 * BIT_DELAY_CYCLES;
	localparam int TMR_W      = $clog2(BIT_CYCLES + 1);
	localparam logic [TMR_W-1:0] TMR_LOAD = TMR_W'(BIT_CYCLES - 1);

	// Latched item
	cmd_t                cmd_q;
	logic [CHAN_W-1:0]   ch_in_q;
	logic [ATIN_W-1:0]   att_in_q;
	logic [WB_W-1:0]     w_q;
	logic [WORD_W-1:0]   raw_q;

	// Architectural state
	logic [WORD_W-1:0]   word_q;
	logic [CHAN_W-1:0]   chan_q;
	logic [ATTEN_W-1:0]  atten_q;
	logic                dev_q;

	// Frame shifter and timer
	logic [WORD_W-1:0]   shift_q;
	logic [WORD_W-1:0]   frame_q;
	logic [BIT_CNT_W-1:0] bit_cnt_q;
	logic [TMR_W-1:0]    tmr_q;

	logic [ATTEN_W-1:0]  att_sat;

	assign att_sat = sat_atten(att_in_q);

	// Item capture
	always_ff @(posedge clk) begin
		if (dp_cmd.op == OP_LATCH) begin
			cmd_q    <= cmd_t'(in_cmd);
			ch_in_q  <= in_channel;
			att_in_q <= in_atten;
			w_q      <= in_w;
			raw_q    <= in_raw;
		end
	end

	// Control word, channel, attenuation and device select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q  <= WORD_RESET;
			chan_q  <= '0;
			atten_q <= ATTEN_RESET;
			dev_q   <= 1'b0;
		end else begin
			if (cfg_we) dev_q <= cfg_wdata;
			case (dp_cmd.op)
				OP_APPLY_CMD: begin
					case (cmd_q)
						CMD_SET_CHAN: begin
							word_q <= chan_word(ch_in_q);
							chan_q <= ch_in_q;
						end
						CMD_SET_ATTEN: begin
							atten_q <= att_sat;
							if (chan_q == CHAN_ATTEN) word_q <= apply_atten(word_q, att_sat);
						end
						CMD_SET_W: begin
							// w bit 1 lands in word bit 6, w bit 0 in word bit 7
							word_q[7] <= w_q[0];
							word_q[6] <= w_q[1];
						end
						CMD_RAW:  word_q <= raw_q;
						default:  ;
					endcase
				end
				OP_APPLY_ATTEN: word_q <= apply_atten(word_q, atten_q);
				default: ;
			endcase
		end
	end

	// Frame shifter, MSB first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q <= '0;
		end else begin
			case (dp_cmd.op)
				OP_LOAD_FRAME: bit_cnt_q <= '0;
				OP_NEXT_BIT:   bit_cnt_q <= bit_cnt_q + 1'b1;
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (dp_cmd.op)
			OP_LOAD_FRAME: begin
				shift_q <= word_q;
				frame_q <= word_q;
			end
			OP_NEXT_BIT: shift_q <= {shift_q[WORD_W-2:0], 1'b0};
			default:     ;
		endcase
	end

	// Bit timer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tmr_q <= '0;
		end else if (dp_cmd.tmr_start) begin
			tmr_q <= TMR_LOAD;
		end else if (tmr_q != '0) begin
			tmr_q <= tmr_q - 1'b1;
		end
	end

	// Status to controller
	always_comb begin
		dp_sts.has_frame  = (cmd_q != CMD_SET_ATTEN) || (chan_q == CHAN_ATTEN);
		dp_sts.two_frames = (cmd_q == CMD_SET_CHAN) && (ch_in_q == CHAN_ATTEN);
		dp_sts.bit_last   = (bit_cnt_q == BIT_LAST);
		dp_sts.tmr_done   = (tmr_q == '0);
	end

	// Out-of-range select saturates to the last device
	assign chip_select = (NUM_DEVICES > 1) ? dev_q : 1'b0;
	assign data_bit    = shift_q[WORD_W-1];
	assign frame_word  = frame_q;

endmodule

`default_nettype wire

// ===== src/rf_switch_atten_spi_controller.sv =====
// Top level of the RF switch/attenuator serial controller.
//
//  Channel | Dir | Signals                      | Beat contents
//  --------+-----+------------------------------+-------------------------------------------
//  s_      | in  | tvalid tready tdata tuser    | one command (cmd in tuser)
//  m_      | out | tvalid tready tdata tuser    | one serial bit; tlast on final bit
//  cfg_    | in  | we wdata                     | device_select register write
//
// One command at a time. A command takes 16 or 32 serial bits (none for set attenuation
// off channel 1); each bit waits for the bit timer to expire and is then offered on the
// output. After the accept, the execute and load states follow, and the channel 1 second
// frame adds attenuation and load states. Output stalls hold the current bit and timing
// restarts after it is taken. Reset restores the channel zero word, channel 0, attenuation
// 40 and device 0.
`timescale 1ns / 1ps
`default_nettype none

module rf_switch_atten_spi_controller #(
	parameter int NUM_DEVICES      = 2,
	parameter int BIT_DELAY_CYCLES = 100
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // channel[2:0], atten_half_db[10:3], w_bits[12:11],
	                                   // raw_word[28:13], zero pad[31:29]
	input  wire logic [1:0]  s_tuser,  // cmd[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,  // data_bit[0], frame_word[16:1], zero pad[23:17]
	output logic [1:0]       m_tuser,  // chip_select[0], frame_end[1]
	output logic             m_tlast,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata
);
	import rfsw_pkg::*;

	dp_cmd_t            dp_cmd;
	dp_sts_t            dp_sts;
	logic               chip_select;
	logic               data_bit;
	logic [WORD_W-1:0]  frame_word;

	rfsw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tlast  (m_tlast),
		.dp_cmd   (dp_cmd),
		.dp_sts   (dp_sts)
	);

	rfsw_dp #(
		.NUM_DEVICES      (NUM_DEVICES),
		.BIT_DELAY_CYCLES (BIT_DELAY_CYCLES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_cmd      (s_tuser),
		.in_channel  (s_tdata[2:0]),
		.in_atten    (s_tdata[10:3]),
		.in_w        (s_tdata[12:11]),
		.in_raw      (s_tdata[28:13]),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.dp_cmd      (dp_cmd),
		.dp_sts      (dp_sts),
		.chip_select (chip_select),
		.data_bit    (data_bit),
		.frame_word  (frame_word)
	);

	// Output beat packing
	assign m_tdata = {7'd0, frame_word, data_bit};
	assign m_tuser = {dp_sts.bit_last, chip_select};

endmodule

`default_nettype wire

// ===== src/rfsw_chk.sv =====
// Port-level checker for the controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rfsw_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata,
	input wire logic [1:0]  m_tuser,
	input wire logic        m_tlast
);

	// A stalled beat holds its contents
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled output beat changed");

	// No new command taken while a bit is on offer
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while output beat pending");

	// Last bit of a command always closes a frame
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[1])
		else $error("last without frame end");

	// The bit timer separates consecutive beats
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |=> !m_tvalid)
		else $error("back-to-back serial bits");

	// After the final bit the block is ready for the next command
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> s_tready)
		else $error("not ready after final bit");

endmodule

bind rf_switch_atten_spi_controller rfsw_chk u_rfsw_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire

// ===== dv/tb_rf_switch_atten_spi_controller.sv =====
// Self-checking testbench for the RF switch/attenuator serial controller.
`timescale 1ns / 1ps

module tb_rf_switch_atten_spi_controller;

	import rfsw_pkg::*;

	localparam int NDEV        = 2;
	// Short bit timing keeps the run small; results do not depend on it
	localparam int BIT_DLY     = 2;
	localparam int SETTLE_CYC  = 12 * BIT_DLY + 20;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		cmd_t             cmd;
		logic [2:0]       chan;
		logic signed [7:0] atten;
		logic [1:0]       wb;
		logic [15:0]      raw;
	} command_t;

	typedef struct {
		logic        cs;
		logic        dbit;
		logic [15:0] word;
		logic        fend;
		logic        tlast;
	} serial_bit_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	wire         s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	wire         m_tvalid;
	logic        m_tready = 1'b0;
	wire  [23:0] m_tdata;
	wire  [1:0]  m_tuser;
	wire         m_tlast;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;

	// Pending commands and serial bits still to come out
	command_t    cmd_queue[$];
	serial_bit_t bit_queue[$];

	// Mirror of the controller state
	logic [15:0] mdl_word = WORD_RESET;
	logic [2:0]  mdl_chan = '0;
	logic [5:0]  mdl_atten = ATTEN_RESET;
	logic        mdl_dev = 1'b0;

	int n_errors = 0;
	int cycles = 0;

	always #5 clk = ~clk;

	rf_switch_atten_spi_controller #(
		.NUM_DEVICES(NDEV),
		.BIT_DELAY_CYCLES(BIT_DLY)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Attenuation word bits: inverted value, low nibble to 15:12, top two to 1:0
	function automatic logic [15:0] atten_word(input logic [15:0] word, input logic [5:0] att);
		logic [5:0] inv;
		inv = ~att;
		return (word & ~16'hF003) | {inv[3:0], 12'h000} | {14'h0000, inv[5:4]};
	endfunction

	// Queue the 16 bits of one frame, MSB first
	task automatic queue_frame(input logic [15:0] word, input logic closes_cmd);
		serial_bit_t sb;
		for (int i = 15; i >= 0; i--) begin
			sb.cs    = (mdl_dev >= NDEV) ? 1'(NDEV - 1) : mdl_dev;
			sb.dbit  = word[i];
			sb.word  = word;
			sb.fend  = (i == 0);
			sb.tlast = closes_cmd && (i == 0);
			bit_queue.push_back(sb);
		end
	endtask

	// Update the mirrored state for one command and queue the bits it sends
	task automatic predict_serial_bits(input command_t c);
		logic [5:0] att;
		case (c.cmd)
			CMD_SET_CHAN: begin
				case (c.chan)
					3'd0:    mdl_word = CHAN0_WORD;
					3'd1:    mdl_word = CHAN1_WORD;
					3'd2:    mdl_word = CHAN2_WORD;
					default: mdl_word = CHAN3_WORD;
				endcase
				mdl_chan = c.chan;
				queue_frame(mdl_word, c.chan != CHAN_ATTEN);
				if (c.chan == CHAN_ATTEN) begin
					mdl_word = atten_word(mdl_word, mdl_atten);
					queue_frame(mdl_word, 1'b1);
				end
			end
			CMD_SET_ATTEN: begin
				if (c.atten < 0)
					att = 6'd0;
				else if (c.atten > 63)
					att = 6'd63;
				else
					att = c.atten[5:0];
				mdl_atten = att;
				if (mdl_chan == CHAN_ATTEN) begin
					mdl_word = atten_word(mdl_word, att);
					queue_frame(mdl_word, 1'b1);
				end
			end
			CMD_SET_W: begin
				mdl_word[6] = c.wb[1];
				mdl_word[7] = c.wb[0];
				queue_frame(mdl_word, 1'b1);
			end
			default: begin
				mdl_word = c.raw;
				queue_frame(mdl_word, 1'b1);
			end
		endcase
	endtask

	// Random command, biased toward channel 1 so attenuation frames go out often
	function automatic command_t random_command();
		command_t c;
		int unsigned pick;
		pick    = $urandom_range(0, 9);
		c.chan  = 3'($urandom);
		c.wb    = 2'($urandom);
		c.raw   = 16'($urandom);
		case ($urandom_range(0, 3))
			0:       c.atten = 8'($urandom_range(0, 63));
			1:       c.atten = ($urandom_range(0, 1) == 1) ? 8'sd127 : -8'sd128;
			default: c.atten = 8'($urandom);
		endcase
		if (pick < 3) begin
			c.cmd = CMD_SET_CHAN;
			if ($urandom_range(0, 1) == 1)
				c.chan = CHAN_ATTEN;
		end else if (pick < 6) begin
			c.cmd = CMD_SET_ATTEN;
		end else if (pick < 8) begin
			c.cmd = CMD_SET_W;
		end else begin
			c.cmd = CMD_RAW;
		end
		return c;
	endfunction

	task automatic queue_cmd(input cmd_t cmd, input logic [2:0] chan,
			input logic signed [7:0] atten, input logic [1:0] wb, input logic [15:0] raw);
		command_t c;
		c.cmd   = cmd;
		c.chan  = chan;
		c.atten = atten;
		c.wb    = wb;
		c.raw   = raw;
		cmd_queue.push_back(c);
	endtask

	task automatic queue_random(input int count);
		@(negedge clk);
		repeat (count) cmd_queue.push_back(random_command());
	endtask

	// Wait until every command is taken and every bit has come out
	task automatic drain();
		do @(negedge clk); while (cmd_queue.size() != 0 || s_tvalid);
		do @(negedge clk); while (bit_queue.size() != 0);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_device(input logic dev);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= dev;
		@(posedge clk);
		cfg_we    <= 1'b0;
		mdl_dev = dev;
	endtask

	task automatic check_field(input string name, input int unsigned exp_v, input int unsigned act_v);
		if (exp_v != act_v) begin
			n_errors++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
		end
	endtask

	// Command driver: bursts of random length separated by random gaps
	int burst_left = 0;
	int gap_left = 0;
	logic offering;

	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			offering = s_tvalid;
			if (s_tvalid && s_tready) begin
				predict_serial_bits(cmd_queue[0]);
				void'(cmd_queue.pop_front());
				offering = 1'b0;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 8);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
				end
			end
			if (!offering) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (cmd_queue.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata  <= {3'b000, cmd_queue[0].raw, cmd_queue[0].wb,
						cmd_queue[0].atten, cmd_queue[0].chan};
					s_tuser  <= cmd_queue[0].cmd;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Bit monitor: checks each beat, stalls on a rotating pattern, long hold-offs
	int unsigned pat_cnt = 0;
	int hold_left = 0;
	int n_beats = 0;
	serial_bit_t want;

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				n_beats++;
				if (bit_queue.size() == 0) begin
					n_errors++;
					$display("%0t: unexpected beat, expected none, got data %0h user %0h last %0b",
						$time, m_tdata, m_tuser, m_tlast);
				end else begin
					want = bit_queue.pop_front();
					check_field("chip_select", want.cs, m_tuser[0]);
					check_field("data_bit", want.dbit, m_tdata[0]);
					check_field("frame_word", want.word, m_tdata[16:1]);
					check_field("frame_end", want.fend, m_tuser[1]);
					check_field("last", want.tlast, m_tlast);
				end
				// Long hold-offs so the controller backs up into its input
				if (n_beats == 120 || n_beats == 1000)
					hold_left = 400;
			end
			pat_cnt++;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (pat_cnt[7:6])
					2'd0:    m_tready <= 1'b1;
					2'd1:    m_tready <= ($urandom_range(0, 1) == 1);
					2'd2:    m_tready <= ($urandom_range(0, 7) != 0);
					default: m_tready <= (pat_cnt % 3 == 0);
				endcase
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL rf_switch_atten_spi_controller");
			$finish;
		end
	end

	// Stimulus sequence
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_device(1'b1);
		@(negedge clk);
		// Channel 1 re-applies the reset attenuation as a second frame
		queue_cmd(CMD_SET_CHAN, 3'd1, 8'sd0, 2'd0, 16'h0000);
		// Attenuation limits and saturation on channel 1
		queue_cmd(CMD_SET_ATTEN, 3'd7, 8'sd0, 2'd3, 16'hFFFF);
		queue_cmd(CMD_SET_ATTEN, 3'd0, 8'sd63, 2'd0, 16'h0000);
		queue_cmd(CMD_SET_ATTEN, 3'd0, 8'sd64, 2'd0, 16'h0000);
		queue_cmd(CMD_SET_ATTEN, 3'd0, 8'sd127, 2'd0, 16'h0000);
		queue_cmd(CMD_SET_ATTEN, 3'd0, -8'sd1, 2'd0, 16'h0000);
		queue_cmd(CMD_SET_ATTEN, 3'd0, -8'sd128, 2'd0, 16'h0000);
		queue_cmd(CMD_SET_ATTEN, 3'd0, 8'sd40, 2'd0, 16'h0000);
		// W bit placement, crossed over
		queue_cmd(CMD_SET_W, 3'd0, 8'sd0, 2'd0, 16'h0000);
		queue_cmd(CMD_SET_W, 3'd0, 8'sd0, 2'd1, 16'h0000);
		queue_cmd(CMD_SET_W, 3'd0, 8'sd0, 2'd2, 16'h0000);
		queue_cmd(CMD_SET_W, 3'd7, -8'sd1, 2'd3, 16'hFFFF);
		queue_cmd(CMD_RAW, 3'd0, 8'sd0, 2'd0, 16'h0000);
		queue_cmd(CMD_RAW, 3'd7, -8'sd1, 2'd3, 16'hFFFF);
		// Attenuation off channel 1 is stored but sends nothing
		queue_cmd(CMD_SET_CHAN, 3'd0, -8'sd1, 2'd3, 16'hFFFF);
		queue_cmd(CMD_SET_ATTEN, 3'd0, 8'sd17, 2'd0, 16'h0000);
		queue_cmd(CMD_SET_CHAN, 3'd2, 8'sd0, 2'd0, 16'h0000);
		queue_cmd(CMD_SET_CHAN, 3'd3, 8'sd0, 2'd0, 16'h0000);
		queue_cmd(CMD_SET_CHAN, 3'd7, -8'sd1, 2'd3, 16'hFFFF);
		queue_cmd(CMD_SET_CHAN, 3'd1, 8'sd0, 2'd0, 16'h0000);
		queue_cmd(CMD_RAW, 3'd0, 8'sd0, 2'd0, 16'h5AA5);
		drain();

		write_device(1'b0);
		queue_random(40);
		drain();

		write_device(1'b1);
		queue_random(40);
		drain();

		if (n_errors == 0)
			$display("PASS rf_switch_atten_spi_controller");
		else
			$display("FAIL rf_switch_atten_spi_controller");
		$finish;
	end

endmodule
